// File: hdl/bmsfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmsfc_pkg;

   // frame layout
   localparam logic [7:0] FRAME_START    = 8'hDD;
   localparam logic [7:0] FRAME_STOP     = 8'h77;
   localparam int         FRAME_OVERHEAD = 7;
   localparam int         MAX_FRAME_BYTES = 256;

   // byte counter, saturating at its top value
   localparam int         COUNT_W     = 9;
   localparam int         TOTAL_W     = COUNT_W + 1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

   // byte positions captured from the head of the frame
   localparam logic [COUNT_W-1:0] POS_START  = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] POS_REG    = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_STATUS = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_LENGTH = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_DATA   = COUNT_W'(4);

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SHORT     = 3'd1,
      ERR_START     = 3'd2,
      ERR_LENGTH    = 3'd3,
      ERR_CHECKSUM  = 3'd4,
      ERR_STOP      = 3'd5
   } error_kind_type;

   typedef struct packed {
      logic           frame_ok;
      error_kind_type error_kind;
      logic [7:0]     register_code;
      logic [7:0]     status_code;
      logic [7:0]     payload_length;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/bmsfc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// byte stream into the checker
interface bmsfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;

   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// one verdict per frame
interface bmsfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_ok;
   logic [2:0] error_kind;
   logic [7:0] register_code;
   logic [7:0] status_code;
   logic [7:0] payload_length;

   modport source (output valid, output frame_ok, output error_kind,
                   output register_code, output status_code,
                   output payload_length, input ready);
   modport sink   (input valid, input frame_ok, input error_kind,
                   input register_code, input status_code,
                   input payload_length, output ready);
endinterface

`default_nettype wire

// File: hdl/bmsfc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bmsfc_core
   import bmsfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   input  wire logic       last_byte,
   output result_type      result
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               start_bad_ff, start_bad_in;
   logic [7:0]         reg_byte_ff, reg_byte_in;
   logic [7:0]         status_byte_ff, status_byte_in;
   logic [7:0]         length_byte_ff, length_byte_in;
   logic [15:0]        running_sum_ff, running_sum_in;
   logic [15:0]        received_check_ff, received_check_in;

   logic [7:0]         reg_cur, status_cur, length_cur;
   logic               start_bad_cur;
   logic [TOTAL_W-1:0] total;
   logic               stop_bad;
   logic               length_bad;
   error_kind_type     err;

   // header bytes as seen with the current request folded in
   always_comb begin
      start_bad_cur = start_bad_ff;
      reg_cur       = reg_byte_ff;
      status_cur    = status_byte_ff;
      length_cur    = length_byte_ff;
      unique case (byte_count_ff)
         POS_START:  start_bad_cur = (rx_byte != FRAME_START);
         POS_REG:    reg_cur       = rx_byte;
         POS_STATUS: status_cur    = rx_byte;
         POS_LENGTH: length_cur    = rx_byte;
         default: begin
         end
      endcase
   end

   // verdict for a final byte
   assign total      = {1'b0, byte_count_ff} + TOTAL_W'(1);
   assign stop_bad   = (rx_byte != FRAME_STOP);
   assign length_bad = (byte_count_ff == COUNT_LIMIT)
                    || (total > TOTAL_W'(MAX_FRAME_BYTES))
                    || ({{(TOTAL_W-8){1'b0}}, length_cur} != total - TOTAL_W'(FRAME_OVERHEAD));

   always_comb begin
      priority if (total < TOTAL_W'(FRAME_OVERHEAD)) begin
         err = ERR_SHORT;
      end else if (start_bad_cur) begin
         err = ERR_START;
      end else if (length_bad) begin
         err = ERR_LENGTH;
      end else if (running_sum_ff != received_check_ff) begin
         err = ERR_CHECKSUM;
      end else if (stop_bad) begin
         err = ERR_STOP;
      end else begin
         err = ERR_NONE;
      end
   end

   always_comb begin
      result.frame_ok       = (err == ERR_NONE);
      result.error_kind     = err;
      result.register_code  = reg_cur;
      result.status_code    = status_cur;
      result.payload_length = length_cur;
   end

   // next state: clear on last byte; else header, count, sum, two-byte window
   always_comb begin
      byte_count_in     = byte_count_ff;
      start_bad_in      = start_bad_ff;
      reg_byte_in       = reg_byte_ff;
      status_byte_in    = status_byte_ff;
      length_byte_in    = length_byte_ff;
      running_sum_in    = running_sum_ff;
      received_check_in = received_check_ff;
      if (accept) begin
         if (last_byte) begin
            byte_count_in     = '0;
            start_bad_in      = 1'b0;
            reg_byte_in       = '0;
            status_byte_in    = '0;
            length_byte_in    = '0;
            running_sum_in    = '0;
            received_check_in = '0;
         end else begin
            start_bad_in   = start_bad_cur;
            reg_byte_in    = reg_cur;
            status_byte_in = status_cur;
            length_byte_in = length_cur;
            if (byte_count_ff >= POS_STATUS) begin
               if (byte_count_ff >= POS_DATA) begin
                  running_sum_in = running_sum_ff - {8'h00, received_check_ff[15:8]};
               end
               received_check_in = {received_check_ff[7:0], rx_byte};
            end
            if (byte_count_ff != COUNT_LIMIT) begin
               byte_count_in = byte_count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff     <= '0;
         start_bad_ff      <= 1'b0;
         reg_byte_ff       <= '0;
         status_byte_ff    <= '0;
         length_byte_ff    <= '0;
         running_sum_ff    <= '0;
         received_check_ff <= '0;
      end else begin
         byte_count_ff     <= byte_count_in;
         start_bad_ff      <= start_bad_in;
         reg_byte_ff       <= reg_byte_in;
         status_byte_ff    <= status_byte_in;
         length_byte_ff    <= length_byte_in;
         running_sum_ff    <= running_sum_in;
         received_check_ff <= received_check_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> byte_count_ff == '0 && running_sum_ff == '0
         && received_check_ff == '0)
      else $error("frame state not cleared after final byte");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !last_byte && byte_count_ff != COUNT_LIMIT
         |=> byte_count_ff == $past(byte_count_ff) + COUNT_W'(1))
      else $error("byte counter did not advance");

   a_start_capture: assert property (@(posedge clock) disable iff (reset)
      accept && !last_byte && byte_count_ff == POS_START
         |=> start_bad_ff == ($past(rx_byte) != FRAME_START))
      else $error("start check not captured");
`endif

endmodule

`default_nettype wire

// File: hdl/bms_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame checker for framed reply buffers: one byte per request, last_byte set on
// the final byte. The block takes one byte every clock cycle while ready is high;
// the byte counter, header capture and the 16-bit negated byte sum all update in
// that cycle. Each final byte yields one verdict (error kind in priority order
// short, bad start, length mismatch, checksum, bad stop) that is registered and
// then shown on the response side. A two-entry output buffer holds verdicts, so
// request ready drops only when two verdicts are waiting; bytes are taken
// without a pause as long as responses are drained. No clearing pass after reset.
module bms_frame_checker
   import bmsfc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   bmsfc_req_if.sink    req_if,
   bmsfc_rsp_if.source  rsp_if
);

   logic       req_accept;
   logic       push;
   logic       pop;
   result_type verdict;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   assign req_if.ready = !skid_valid_ff;
   assign req_accept   = req_if.valid && req_if.ready;
   assign push         = req_accept && req_if.last_byte;
   assign pop          = out_valid_ff && rsp_if.ready;

   bmsfc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_if.rx_byte),
      .last_byte (req_if.last_byte),
      .result    (verdict)
   );

   // two-entry output buffer, skid entry used only when the head is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (!out_valid_ff) begin
         out_valid_in = push;
         out_data_in  = verdict;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = verdict;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.frame_ok       = out_data_ff.frame_ok;
   assign rsp_if.error_kind     = out_data_ff.error_kind;
   assign rsp_if.register_code  = out_data_ff.register_code;
   assign rsp_if.status_code    = out_data_ff.status_code;
   assign rsp_if.payload_length = out_data_ff.payload_length;

`ifndef SYNTHESIS
   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a head entry");

   a_last_fills_head: assert property (@(posedge clock) disable iff (reset)
      push && !out_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("verdict not loaded into empty buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> out_valid_ff && !skid_valid_ff
         && out_data_ff == $past(skid_data_ff))
      else $error("skid entry not moved to head");
`endif

endmodule

`default_nettype wire
